### src/csdc_pkg.sv
// Shared types, event and mode codes, and helper functions for the clock
// set-and-display controller. No dependencies.
package csdc_pkg;

  // Event codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MODE = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;
  localparam logic [1:0] OP_DOWN = 2'd3;

  // Mode codes
  localparam logic [1:0] MODE_SHOW = 2'd0;
  localparam logic [1:0] MODE_HOUR = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [5:0] HOUR_LIMIT = 6'd24;
  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [6:0] MIN_MAX    = 7'd59;

  localparam logic [15:0] MARK_HOUR = 16'h8000;
  localparam logic [15:0] MARK_MIN  = 16'h4000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rtc_minute_bcd;
    logic [7:0] rtc_hour_bcd;
  } item_t;

  typedef struct packed {
    logic [15:0] led_word;
    logic        rtc_write;
    logic [6:0]  write_minute_bcd;
    logic [5:0]  write_hour_bcd;
  } result_t;

  // Swap the low byte: bits 7..5 -> 2..0, bits 4..0 -> 7..3.
  function automatic logic [15:0] led_map(input logic [15:0] x);
    return {x[15:8], x[4:0], x[7:5]};
  endfunction

  // Binary to two BCD digits, tens taken modulo 10. x*205>>11 is exact x/10 here.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    rem  = v - 7'(tens) * 7'd10;
    if (tens >= 4'd10) begin
      tens = tens - 4'd10;
    end
    return {tens, rem[3:0]};
  endfunction

endpackage

### src/csdc_in_stage.sv
// Input register of the clock controller: holds one event until the core takes it.
// Depends on csdc_pkg.
module csdc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  csdc_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output csdc_pkg::item_t item
);

  // Refill when empty or when the held event leaves this cycle
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### src/csdc_core.sv
// Mode, time and blink state with the per-event update and result logic.
// Depends on csdc_pkg.
module csdc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  csdc_pkg::item_t  item,
  input  logic             out_ready,
  output logic             take,
  output logic             res_valid,
  output csdc_pkg::result_t res
);

  logic [1:0] mode_state, mode_state_next;
  logic [5:0] hours, hours_next;
  logic [6:0] minutes, minutes_next;
  logic       blink_phase, blink_phase_next;

  logic        is_tick;
  logic [5:0]  hour_inc, hour_up, hour_dn;
  logic [6:0]  min_inc;
  logic [6:0]  ld_min;
  logic [5:0]  ld_hour;
  logic [7:0]  min_digits, hr_digits;
  logic [15:0] full_x;

  assign is_tick   = (item.op == csdc_pkg::OP_TICK);
  // Buttons give no result, so they never wait on the output
  assign take      = item_valid && (!is_tick || out_ready);
  assign res_valid = take && is_tick;

  assign hour_inc = hours + 6'd1;
  assign hour_up  = (hour_inc >= csdc_pkg::HOUR_LIMIT) ? 6'd0 : hour_inc;
  assign hour_dn  = (hours == 6'd0) ? csdc_pkg::HOUR_MAX : hours - 6'd1;
  assign min_inc  = minutes + 7'd1;

  // Load from the clock chip, no range check
  assign ld_min  = 7'(item.rtc_minute_bcd[6:4]) * 7'd10 + 7'(item.rtc_minute_bcd[3:0]);
  assign ld_hour = 6'(item.rtc_hour_bcd[5:4]) * 6'd10 + 6'(item.rtc_hour_bcd[3:0]);

  assign min_digits = csdc_pkg::to_bcd(minutes);
  assign hr_digits  = csdc_pkg::to_bcd({1'b0, hours});
  assign full_x     = {4'd0, minutes, 5'd0} | {10'd0, hours};

  always_comb begin
    mode_state_next  = mode_state;
    hours_next       = hours;
    minutes_next     = minutes;
    blink_phase_next = blink_phase;
    res              = '0;
    unique case (item.op)
      csdc_pkg::OP_MODE: begin
        unique case (mode_state)
          csdc_pkg::MODE_SHOW: mode_state_next = csdc_pkg::MODE_HOUR;
          csdc_pkg::MODE_HOUR: mode_state_next = csdc_pkg::MODE_MIN;
          csdc_pkg::MODE_MIN:  mode_state_next = csdc_pkg::MODE_SHOW;
          default:             mode_state_next = csdc_pkg::MODE_HOUR;
        endcase
      end
      csdc_pkg::OP_UP: begin
        if (mode_state == csdc_pkg::MODE_HOUR) begin
          hours_next = hour_up;
        end else if (mode_state == csdc_pkg::MODE_MIN) begin
          if (min_inc >= csdc_pkg::MIN_LIMIT) begin
            minutes_next = 7'd0;
            hours_next   = hour_up;
          end else begin
            minutes_next = min_inc;
          end
        end
      end
      csdc_pkg::OP_DOWN: begin
        if (mode_state == csdc_pkg::MODE_HOUR) begin
          hours_next = hour_dn;
        end else if (mode_state == csdc_pkg::MODE_MIN) begin
          if (minutes == 7'd0) begin
            minutes_next = csdc_pkg::MIN_MAX;
            hours_next   = hour_dn;
          end else begin
            minutes_next = minutes - 7'd1;
          end
        end
      end
      default: begin
        blink_phase_next = !blink_phase;
        unique case (mode_state) inside
          csdc_pkg::MODE_SHOW: begin
            minutes_next = ld_min;
            hours_next   = ld_hour;
            res.led_word = csdc_pkg::led_map({4'd0, ld_min, 5'd0} | {10'd0, ld_hour});
          end
          csdc_pkg::MODE_HOUR, csdc_pkg::MODE_MIN: begin
            res.rtc_write        = 1'b1;
            res.write_minute_bcd = {min_digits[6:4], min_digits[3:0]};
            res.write_hour_bcd   = {hr_digits[5:4], hr_digits[3:0]};
            if (mode_state == csdc_pkg::MODE_HOUR) begin
              // selected field dark on the even phase
              res.led_word = (blink_phase_next ? csdc_pkg::led_map(full_x)
                              : csdc_pkg::led_map({4'd0, minutes, 5'd0}))
                             | csdc_pkg::MARK_HOUR;
            end else begin
              res.led_word = (blink_phase_next ? csdc_pkg::led_map(full_x)
                              : csdc_pkg::led_map({10'd0, hours}))
                             | csdc_pkg::MARK_MIN;
            end
          end
          default: res = '0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state  <= csdc_pkg::MODE_SHOW;
      hours       <= 6'd0;
      minutes     <= 7'd0;
      blink_phase <= 1'b0;
    end else if (take) begin
      mode_state  <= mode_state_next;
      hours       <= hours_next;
      minutes     <= minutes_next;
      blink_phase <= blink_phase_next;
    end
  end

endmodule

### src/csdc_out_stage.sv
// Result register of the clock controller; holds a result until it is taken.
// Depends on csdc_pkg.
module csdc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  csdc_pkg::result_t res,
  output logic              out_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output csdc_pkg::result_t out_res
);

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### src/clock_set_and_display_controller.sv
// Clock set-and-display controller: input register, event core, result register.
// A tick's event passes the input register and the core and is registered in the result
// register, from which it transfers out; buttons give none.
// Throughput: one event per cycle; only a tick waits, and only on a stalled full result.
// Reset (rst, synchronous): show mode, time 00:00, blink phase 0, both stages empty.
// Depends on csdc_pkg, csdc_in_stage, csdc_core, csdc_out_stage.
module clock_set_and_display_controller (
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  rtc_minute_bcd,
  input  logic [7:0]  rtc_hour_bcd,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] led_word,
  output logic        rtc_write,
  output logic [6:0]  write_minute_bcd,
  output logic [5:0]  write_hour_bcd
);

  csdc_pkg::item_t   in_item, item;
  csdc_pkg::result_t res, out_res;
  logic item_valid, take, res_valid, out_ready;

  assign in_item.op             = op;
  assign in_item.rtc_minute_bcd = rtc_minute_bcd;
  assign in_item.rtc_hour_bcd   = rtc_hour_bcd;

  // Event register: the transfer in lands here
  csdc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // State update and result build in one pass
  csdc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register; parts the event side from a stalled consumer
  csdc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign led_word         = out_res.led_word;
  assign rtc_write        = out_res.rtc_write;
  assign write_minute_bcd = out_res.write_minute_bcd;
  assign write_hour_bcd   = out_res.write_hour_bcd;

endmodule

### src/csdc_checker.sv
// Port-level checks for the clock set-and-display controller, bound to the top level.
// Depends on clock_set_and_display_controller.
module csdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] led_word,
  input logic        rtc_write,
  input logic [6:0]  write_minute_bcd,
  input logic [5:0]  write_hour_bcd
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(led_word) && $stable(rtc_write))
    else $error("stalled result changed");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && rtc_write |-> (led_word[15] != led_word[14]))
    else $error("set mode without exactly one mode mark");

  a_show: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rtc_write |->
      write_minute_bcd == 7'd0 && write_hour_bcd == 6'd0 && led_word[15:14] == 2'd0)
    else $error("show-mode result carries write data or marks");

  a_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_minute_bcd[3:0] <= 4'd9 && write_hour_bcd[3:0] <= 4'd9)
    else $error("BCD units digit above nine");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind clock_set_and_display_controller csdc_checker u_csdc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .led_word         (led_word),
  .rtc_write        (rtc_write),
  .write_minute_bcd (write_minute_bcd),
  .write_hour_bcd   (write_hour_bcd)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for clock_set_and_display_controller: directed and random events,
// with each result checked against an in-bench model. Depends on csdc_pkg and the RTL.
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = csdc_pkg::OP_TICK;
  logic [7:0]  rtc_minute_bcd = 8'h00;
  logic [7:0]  rtc_hour_bcd = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] led_word;
  logic        rtc_write;
  logic [6:0]  write_minute_bcd;
  logic [5:0]  write_hour_bcd;

  // Idle percentages for each side; changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;

  // Results owed by the block, oldest first; one per accepted tick.
  csdc_pkg::result_t expected_displays[$];

  // Model of the controller state.
  logic [1:0] model_mode = csdc_pkg::MODE_SHOW;
  logic [5:0] model_hours = '0;
  logic [6:0] model_minutes = '0;
  logic       model_blink = 1'b0;

  clock_set_and_display_controller u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .rtc_minute_bcd   (rtc_minute_bcd),
    .rtc_hour_bcd     (rtc_hour_bcd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .led_word         (led_word),
    .rtc_write        (rtc_write),
    .write_minute_bcd (write_minute_bcd),
    .write_hour_bcd   (write_hour_bcd)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[clock_set_and_display_controller] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Low byte reorder: bits 7..5 go to 2..0, bits 4..0 go to 7..3, high byte kept.
  function automatic logic [15:0] led_pattern(input logic [15:0] x);
    return ((x & 16'h00E0) >> 5) | ((x & 16'h001F) << 3) | (x & 16'hFF00);
  endfunction

  // Minutes over hours; hours bit 5 lands on minutes bit 0 and the two are ORed.
  function automatic logic [15:0] time_bits(input logic [6:0] m, input logic [5:0] h);
    return (16'(m) << 5) | 16'(h);
  endfunction

  function automatic void model_hour_up();
    model_hours = model_hours + 6'd1;
    if (model_hours >= csdc_pkg::HOUR_LIMIT) begin
      model_hours = '0;
    end
  endfunction

  function automatic void model_hour_down();
    if (model_hours == '0) begin
      model_hours = csdc_pkg::HOUR_MAX;
    end else begin
      model_hours = model_hours - 6'd1;
    end
  endfunction

  // Applies one event to the model; returns 1 with the display result for a tick.
  function automatic bit predict_display(input logic [1:0] ev, input logic [7:0] mb,
                                         input logic [7:0] hb,
                                         output csdc_pkg::result_t res);
    logic [15:0] full;
    res = '0;
    case (ev)
      csdc_pkg::OP_MODE: begin
        model_mode = 2'((model_mode + 3'd1) % 3'd3);
        return 1'b0;
      end
      csdc_pkg::OP_UP: begin
        if (model_mode == csdc_pkg::MODE_HOUR) begin
          model_hour_up();
        end else if (model_mode == csdc_pkg::MODE_MIN) begin
          model_minutes = model_minutes + 7'd1;
          if (model_minutes >= csdc_pkg::MIN_LIMIT) begin
            model_minutes = '0;
            model_hour_up();
          end
        end
        return 1'b0;
      end
      csdc_pkg::OP_DOWN: begin
        if (model_mode == csdc_pkg::MODE_HOUR) begin
          model_hour_down();
        end else if (model_mode == csdc_pkg::MODE_MIN) begin
          if (model_minutes == '0) begin
            model_hour_down();
            model_minutes = csdc_pkg::MIN_MAX;
          end else begin
            model_minutes = model_minutes - 7'd1;
          end
        end
        return 1'b0;
      end
      default: begin
        model_blink = ~model_blink;
        case (model_mode) inside
          csdc_pkg::MODE_SHOW: begin
            // Clock chip bytes taken as BCD with no range check
            model_minutes = 7'(int'(mb[6:4]) * 10 + int'(mb[3:0]));
            model_hours   = 6'(int'(hb[5:4]) * 10 + int'(hb[3:0]));
            res.led_word  = led_pattern(time_bits(model_minutes, model_hours));
          end
          csdc_pkg::MODE_HOUR, csdc_pkg::MODE_MIN: begin
            res.rtc_write        = 1'b1;
            res.write_minute_bcd = {3'(model_minutes / 10 % 10), 4'(model_minutes % 10)};
            res.write_hour_bcd   = {2'(model_hours / 10 % 10), 4'(model_hours % 10)};
            full = led_pattern(time_bits(model_minutes, model_hours));
            // Selected field blanked on the even blink phase
            if (model_mode == csdc_pkg::MODE_HOUR) begin
              res.led_word = (model_blink ? full
                                          : led_pattern(time_bits(model_minutes, 6'd0)))
                             | csdc_pkg::MARK_HOUR;
            end else begin
              res.led_word = (model_blink ? full
                                          : led_pattern(time_bits(7'd0, model_hours)))
                             | csdc_pkg::MARK_MIN;
            end
          end
          default: ;
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // One event transfer, after a random idle gap; the model steps at acceptance.
  task automatic send_event(input logic [1:0] ev, input logic [7:0] mb, input logic [7:0] hb);
    csdc_pkg::result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= ev;
    rtc_minute_bcd <= mb;
    rtc_hour_bcd   <= hb;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    if (predict_display(ev, mb, hb, res)) begin
      expected_displays.push_back(res);
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    csdc_pkg::result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_displays.size() == 0) begin
        $error("result with none pending: led_word %h", led_word);
        mismatches++;
      end else begin
        want = expected_displays.pop_front();
        if (led_word !== want.led_word) begin
          $error("led_word: expected %h, got %h", want.led_word, led_word);
          mismatches++;
        end
        if (rtc_write !== want.rtc_write) begin
          $error("rtc_write: expected %b, got %b", want.rtc_write, rtc_write);
          mismatches++;
        end
        if (write_minute_bcd !== want.write_minute_bcd) begin
          $error("write_minute_bcd: expected %h, got %h",
                 want.write_minute_bcd, write_minute_bcd);
          mismatches++;
        end
        if (write_hour_bcd !== want.write_hour_bcd) begin
          $error("write_hour_bcd: expected %h, got %h", want.write_hour_bcd, write_hour_bcd);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Loading from the clock chip in show mode; buttons other than mode do nothing.
  task automatic test_clock_load();
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_UP,   8'h12, 8'h34);
    send_event(csdc_pkg::OP_DOWN, 8'h56, 8'h78);
    send_event(csdc_pkg::OP_TICK, 8'h80, 8'hC0);  // bits above the BCD digits ignored
    send_event(csdc_pkg::OP_TICK, 8'hFF, 8'hFF);  // 85 minutes, 45 hours, overlapping LED bit
  endtask

  // Hour setting from an out-of-range hour, both blink phases, wrap both ways.
  task automatic test_hour_setting();
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_TICK, 8'hFF, 8'hFF);
    send_event(csdc_pkg::OP_UP,   8'h00, 8'h00);  // 45 wraps straight to 0
    send_event(csdc_pkg::OP_DOWN, 8'h00, 8'h00);  // 0 to 23
    send_event(csdc_pkg::OP_DOWN, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_UP,   8'h00, 8'h00);
    send_event(csdc_pkg::OP_UP,   8'h00, 8'h00);  // 23 to 0
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
  endtask

  // Minute setting: carry and borrow into the hour, including midnight both ways.
  task automatic test_minute_setting();
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_UP,   8'h00, 8'h00);  // 85 out of range, wraps and carries
    send_event(csdc_pkg::OP_DOWN, 8'h00, 8'h00);  // borrow back
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);  // reload 00:00
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_DOWN, 8'h00, 8'h00);  // 00:00 borrows to 23:59
    send_event(csdc_pkg::OP_UP,   8'h00, 8'h00);  // and carries back to 00:00
    send_event(csdc_pkg::OP_TICK, 8'h00, 8'h00);
    send_event(csdc_pkg::OP_MODE, 8'h00, 8'h00);
  endtask

  // Mostly plausible BCD bytes, some fully random.
  function automatic logic [7:0] random_minute_byte();
    if ($urandom_range(4) == 0) begin
      return 8'($urandom_range(255));
    end
    return {4'($urandom_range(5)), 4'($urandom_range(9))};
  endfunction

  function automatic logic [7:0] random_hour_byte();
    logic [3:0] tens;
    if ($urandom_range(4) == 0) begin
      return 8'($urandom_range(255));
    end
    tens = 4'($urandom_range(2));
    return {tens, 4'($urandom_range(tens == 4'd2 ? 3 : 9))};
  endfunction

  // Random events; up and down sometimes come in runs long enough to wrap.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int count);
    int unsigned pick;
    int          run_len;
    logic [1:0]  ev;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (count > 0) begin
      pick = $urandom_range(99);
      run_len = 1;
      if (pick < 35) begin
        ev = csdc_pkg::OP_TICK;
      end else if (pick < 47) begin
        ev = csdc_pkg::OP_MODE;
      end else begin
        ev = (pick < 74) ? csdc_pkg::OP_UP : csdc_pkg::OP_DOWN;
        if ($urandom_range(9) == 0) begin
          run_len = $urandom_range(40, 5);
        end
      end
      repeat (run_len) begin
        send_event(ev, random_minute_byte(), random_hour_byte());
      end
      count -= run_len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 77;
    test_clock_load();
    test_hour_setting();
    test_minute_setting();

    test_random_traffic(38, 77, 580);
    test_random_traffic(77, 38, 580);
    test_random_traffic(0, 0, 580);

    // Drain: last transfer done, wait for every owed result, then a few spare cycles
    in_valid <= 1'b0;
    while (expected_displays.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);

    if (mismatches == 0) begin
      $display("[clock_set_and_display_controller] OK");
    end else begin
      $display("[clock_set_and_display_controller] ERROR");
    end
    $finish;
  end

endmodule
